// File: hw/rtl/ncomix_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NCO tone crossfade mixer package
// Shared widths, register map, reset values, pipeline control type and the
// quarter-wave sine generator used to build the tone ROM.
// ----------------------------------------------------------------------------
package ncomix_pkg;

   localparam int SAMPLE_BITS              = 16;
   localparam int AMP_BITS                 = SAMPLE_BITS - 1;
   localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;

   localparam int PHASE_BITS     = 32;
   localparam int PHASE_INC_BITS = 31;
   localparam int GAIN_BITS      = 17;
   localparam int INV_BITS       = 25;
   localparam int ACC_BITS       = 41;   // gain accumulator, Q1.40
   localparam int STEP_BITS      = 42;   // signed ramp step, Q1.40
   localparam int GAIN_SHIFT     = 24;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'd65536;
   localparam logic [INV_BITS-1:0]  INV_MAX  = 25'd16777216;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Register map
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_INDEX_BITS = 2;
   localparam logic [REG_INDEX_BITS-1:0] REG_PHASE_INC  = 2'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_WET_TARGET = 2'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_INV_LENGTH = 2'd2;

   localparam logic [PHASE_INC_BITS-1:0] PHASE_INC_RESET  = 31'd42852281;
   localparam logic [GAIN_BITS-1:0]      WET_TARGET_RESET = 17'd65536;
   localparam logic [INV_BITS-1:0]       INV_LENGTH_RESET = 25'd16384;

   typedef struct packed {
      logic s0_load;
      logic s1_load;
      logic s2_load;
      logic out_load;
   } stage_ctrl_type;

   // Sine of x (Q2.30, 0..pi/2) by a Taylor series through x^17, scaled to the
   // positive sample range. Only evaluated at elaboration to fill the ROM.
   function automatic logic [AMP_BITS-1:0] quarter_sine(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] s;
      logic [63:0]        amp;
      logic [63:0]        r;
      x2   = (x * x) >> 30;
      amp  = (64'd1 << AMP_BITS) - 64'd1;
      term = x;
      s    = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;   s = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;  s = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;  s = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;  s = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd110; s = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd156; s = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd210; s = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd272; s = s + $signed(term);
      if (s < 0) begin
         s = 64'sd0;
      end
      if (s > 64'sd1073741824) begin
         s = 64'sd1073741824;
      end
      r = ($unsigned(s) * amp + (64'd1 << 29)) >> 30;
      if (r > amp) begin
         r = amp;
      end
      return r[AMP_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ncomix_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NCO tone crossfade mixer: phase and gain state
// Holds the phase accumulator and the per-buffer gain ramp, and captures each
// accepted sample together with its phase and gain into the first stage.
// ----------------------------------------------------------------------------
module ncomix_state (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   load,
   input  wire logic signed [ncomix_pkg::SAMPLE_BITS-1:0]  dry_sample,
   input  wire logic                                   last_in_buffer,
   input  wire logic                                   disabling,
   input  wire logic [ncomix_pkg::PHASE_INC_BITS-1:0]  phase_increment,
   input  wire logic [ncomix_pkg::GAIN_BITS-1:0]       wet_target,
   input  wire logic [ncomix_pkg::INV_BITS-1:0]        inverse_buffer_length,
   output logic [ncomix_pkg::PHASE_BITS-1:0]           phase_ff,
   output logic [ncomix_pkg::GAIN_BITS-1:0]            gain_ff,
   output logic signed [ncomix_pkg::SAMPLE_BITS-1:0]   dry_ff
);

   localparam int DIFF_BITS = ncomix_pkg::GAIN_BITS + 1;
   localparam int MULT_BITS = DIFF_BITS + ncomix_pkg::INV_BITS + 1;
   localparam int SUM_BITS  = ncomix_pkg::STEP_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] ACC_MAX =
      SUM_BITS'(64'd1 << (ncomix_pkg::ACC_BITS - 1));

   logic [ncomix_pkg::PHASE_BITS-1:0]        phase_acc_ff, phase_acc_in;
   logic [ncomix_pkg::GAIN_BITS-1:0]         prev_gain_ff, prev_gain_in;
   logic [ncomix_pkg::ACC_BITS-1:0]          cur_gain_ff, cur_gain_in;
   logic signed [ncomix_pkg::STEP_BITS-1:0]  ramp_step_ff, ramp_step_in;
   logic                                     buffer_start_ff, buffer_start_in;

   logic [ncomix_pkg::GAIN_BITS-1:0]         target_sat;
   logic [ncomix_pkg::INV_BITS-1:0]          inv_sat;
   logic signed [DIFF_BITS-1:0]              gain_diff;
   logic signed [MULT_BITS-1:0]              step_prod;
   logic signed [SUM_BITS-1:0]               gain_sum;
   logic [ncomix_pkg::ACC_BITS-1:0]          gain_sum_sat;

   always_comb begin
      target_sat = (wet_target > ncomix_pkg::GAIN_ONE) ? ncomix_pkg::GAIN_ONE : wet_target;
      inv_sat    = (inverse_buffer_length > ncomix_pkg::INV_MAX) ?
                   ncomix_pkg::INV_MAX : inverse_buffer_length;
      gain_diff  = $signed({1'b0, target_sat}) - $signed({1'b0, prev_gain_ff});
      step_prod  = MULT_BITS'(gain_diff) * $signed(MULT_BITS'({1'b0, inv_sat}));

      // The running gain moves on by one step per sample and is held in 0..1.
      gain_sum = $signed(SUM_BITS'({1'b0, cur_gain_ff})) + SUM_BITS'(ramp_step_ff);
      if (gain_sum < 0) begin
         gain_sum_sat = '0;
      end else if (gain_sum > ACC_MAX) begin
         gain_sum_sat = ACC_MAX[ncomix_pkg::ACC_BITS-1:0];
      end else begin
         gain_sum_sat = gain_sum[ncomix_pkg::ACC_BITS-1:0];
      end
   end

   always_comb begin
      phase_acc_in    = phase_acc_ff;
      prev_gain_in    = prev_gain_ff;
      cur_gain_in     = cur_gain_ff;
      ramp_step_in    = ramp_step_ff;
      buffer_start_in = buffer_start_ff;
      if (load) begin
         phase_acc_in = phase_acc_ff + ncomix_pkg::PHASE_BITS'(phase_increment);
         if (buffer_start_ff) begin
            cur_gain_in  = {prev_gain_ff, ncomix_pkg::GAIN_SHIFT'(0)};
            ramp_step_in = step_prod[ncomix_pkg::STEP_BITS-1:0];
         end else begin
            cur_gain_in  = gain_sum_sat;
         end
         buffer_start_in = last_in_buffer;
         if (last_in_buffer) begin
            prev_gain_in = disabling ? '0 : target_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         prev_gain_ff    <= '0;
         cur_gain_ff     <= '0;
         ramp_step_ff    <= '0;
         buffer_start_ff <= 1'b1;
      end else begin
         phase_acc_ff    <= phase_acc_in;
         prev_gain_ff    <= prev_gain_in;
         cur_gain_ff     <= cur_gain_in;
         ramp_step_ff    <= ramp_step_in;
         buffer_start_ff <= buffer_start_in;
      end
   end

   // The tone uses the phase before it advances.
   always_ff @(posedge clock) begin
      if (load) begin
         phase_ff <= phase_acc_ff;
         gain_ff  <= cur_gain_in[ncomix_pkg::ACC_BITS-1:ncomix_pkg::GAIN_SHIFT];
         dry_ff   <= dry_sample;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ncomix_tone.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NCO tone crossfade mixer: tone lookup
// Maps a phase to a quadrant and a quarter-wave ROM address, and reads the
// ROM into a registered magnitude with a sign flag.
// ----------------------------------------------------------------------------
module ncomix_tone #(
   parameter int SINE_TABLE_DEPTH = ncomix_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire logic [ncomix_pkg::PHASE_BITS-1:0]   phase,
   output logic [ncomix_pkg::AMP_BITS-1:0]          tone_mag_ff,
   output logic                                     tone_neg_ff
);

   localparam int IDX_MUL   = 4 * SINE_TABLE_DEPTH;
   localparam int IDX_BITS  = $clog2(IDX_MUL);
   localparam int MUL_BITS  = $clog2(IDX_MUL + 1);
   localparam int PROD_BITS = ncomix_pkg::PHASE_BITS + MUL_BITS;
   localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [IDX_BITS-1:0] Q1_START = IDX_BITS'(SINE_TABLE_DEPTH);
   localparam logic [IDX_BITS-1:0] Q2_START = IDX_BITS'(2 * SINE_TABLE_DEPTH);
   localparam logic [IDX_BITS-1:0] Q3_START = IDX_BITS'(3 * SINE_TABLE_DEPTH);
   localparam logic [ADDR_BITS-1:0] ADDR_TOP = ADDR_BITS'(SINE_TABLE_DEPTH);

   logic [ncomix_pkg::AMP_BITS-1:0] sine_rom [0:SINE_TABLE_DEPTH];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [63:0] X_Q30 = (ncomix_pkg::HALF_PI_Q30 * 64'(g)) / SINE_TABLE_DEPTH;
      localparam logic [ncomix_pkg::AMP_BITS-1:0] ENTRY = ncomix_pkg::quarter_sine(X_Q30);
      assign sine_rom[g] = ENTRY;
   end

   logic [PROD_BITS-1:0]  idx_prod;
   logic [IDX_BITS-1:0]   idx;
   logic [1:0]            quadrant;
   logic [IDX_BITS-1:0]   quad_start;
   logic [IDX_BITS-1:0]   offset;
   logic [ADDR_BITS-1:0]  rom_addr;

   always_comb begin
      idx_prod = PROD_BITS'(phase) * PROD_BITS'(IDX_MUL);
      idx      = idx_prod[ncomix_pkg::PHASE_BITS +: IDX_BITS];
      if (idx >= Q3_START) begin
         quadrant   = 2'd3;
         quad_start = Q3_START;
      end else if (idx >= Q2_START) begin
         quadrant   = 2'd2;
         quad_start = Q2_START;
      end else if (idx >= Q1_START) begin
         quadrant   = 2'd1;
         quad_start = Q1_START;
      end else begin
         quadrant   = 2'd0;
         quad_start = '0;
      end
      offset = idx - quad_start;
      // Odd quadrants run the quarter wave backwards.
      rom_addr = quadrant[0] ? (ADDR_TOP - offset[ADDR_BITS-1:0]) : offset[ADDR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tone_mag_ff <= sine_rom[rom_addr];
         tone_neg_ff <= quadrant[1];
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ncomix_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NCO tone crossfade mixer: dry/wet mix
// Forms gain * (tone - dry), rounds it, adds the dry sample and saturates.
// ----------------------------------------------------------------------------
module ncomix_mix (
   input  wire logic                                    clock,
   input  wire ncomix_pkg::stage_ctrl_type              ctrl,
   input  wire logic signed [ncomix_pkg::SAMPLE_BITS-1:0]  dry_sample,
   input  wire logic [ncomix_pkg::GAIN_BITS-1:0]        gain,
   input  wire logic [ncomix_pkg::AMP_BITS-1:0]         tone_mag,
   input  wire logic                                    tone_neg,
   output logic signed [ncomix_pkg::SAMPLE_BITS-1:0]    mixed_ff
);

   localparam int DIFF_BITS  = ncomix_pkg::SAMPLE_BITS + 2;
   localparam int PROD_BITS  = ncomix_pkg::GAIN_BITS + 1 + DIFF_BITS;
   localparam int FRAC_BITS  = 16;
   localparam int MIX_BITS   = PROD_BITS - FRAC_BITS + 1;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [MIX_BITS-1:0]  SAT_MAX =
      MIX_BITS'((64'd1 << (ncomix_pkg::SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [MIX_BITS-1:0]  SAT_MIN =
      MIX_BITS'(-(64'sd1 <<< (ncomix_pkg::SAMPLE_BITS - 1)));

   logic signed [ncomix_pkg::SAMPLE_BITS-1:0] dry1_ff, dry2_ff;
   logic [ncomix_pkg::GAIN_BITS-1:0]          gain1_ff;
   logic signed [PROD_BITS-1:0]               prod_ff;

   logic signed [DIFF_BITS-1:0]               tone_val;
   logic signed [DIFF_BITS-1:0]               diff;
   logic signed [PROD_BITS-1:0]               prod;
   logic signed [PROD_BITS-1:0]               rounded;
   logic signed [MIX_BITS-1:0]                mixed_wide;
   logic signed [ncomix_pkg::SAMPLE_BITS-1:0] mixed_sat;

   always_comb begin
      tone_val = tone_neg ? -$signed(DIFF_BITS'(tone_mag)) : $signed(DIFF_BITS'(tone_mag));
      diff     = tone_val - DIFF_BITS'(dry1_ff);
      prod     = $signed(PROD_BITS'(gain1_ff)) * PROD_BITS'(diff);
   end

   always_comb begin
      // Taking the upper bits of the rounded product floors toward minus infinity.
      rounded    = prod_ff + ROUND_HALF;
      mixed_wide = MIX_BITS'(dry2_ff) + MIX_BITS'($signed(rounded[PROD_BITS-1:FRAC_BITS]));
      if (mixed_wide > SAT_MAX) begin
         mixed_sat = SAT_MAX[ncomix_pkg::SAMPLE_BITS-1:0];
      end else if (mixed_wide < SAT_MIN) begin
         mixed_sat = SAT_MIN[ncomix_pkg::SAMPLE_BITS-1:0];
      end else begin
         mixed_sat = mixed_wide[ncomix_pkg::SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         dry1_ff  <= dry_sample;
         gain1_ff <= gain;
      end
      if (ctrl.s2_load) begin
         prod_ff <= prod;
         dry2_ff <= dry1_ff;
      end
      if (ctrl.out_load) begin
         mixed_ff <= mixed_sat;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/nco_sine_tone_crossfade_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NCO sine tone crossfade mixer
// Mixes an audio stream with a sine tone under a per-buffer gain ramp.
// ----------------------------------------------------------------------------
// The block takes one signed 16-bit sample per transaction and returns one
// mixed sample per transaction, in order. A new sample can be accepted in
// every cycle while the result stream is not stalled. Each accepted sample
// passes through four register stages before its result is valid on the output:
// the phase and gain capture (both recurrences close there), the registered
// read of the quarter-wave sine ROM, the gain multiplier and the output
// register. Flow control lets each stage fill while a later one is stalled,
// so input is still taken while a finished result waits. Registers are
// written over the APB port (phase increment at 0x0, wet target at 0x4,
// inverse buffer length at 0x8); the user must write them only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module nco_sine_tone_crossfade_mixer #(
   parameter int SINE_TABLE_DEPTH = ncomix_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Input stream
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [ncomix_pkg::SAMPLE_BITS-1:0]     req_tdata,  // [15:0] dry_sample
   input  wire logic                                   req_tlast,  // last_in_buffer
   input  wire logic                                   req_tuser,  // [0] disabling
   // Result stream
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [ncomix_pkg::SAMPLE_BITS-1:0]          rsp_tdata,  // [15:0] mixed_sample
   // Configuration
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [ncomix_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [ncomix_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ncomix_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                        csr_pready
);

   logic [ncomix_pkg::PHASE_INC_BITS-1:0] phase_inc_ff, phase_inc_in;
   logic [ncomix_pkg::GAIN_BITS-1:0]      wet_target_ff, wet_target_in;
   logic [ncomix_pkg::INV_BITS-1:0]       inv_length_ff, inv_length_in;
   logic [ncomix_pkg::REG_INDEX_BITS-1:0] reg_index;
   logic                                  csr_write;

   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   ncomix_pkg::stage_ctrl_type ctrl;

   logic [ncomix_pkg::PHASE_BITS-1:0]           phase0;
   logic [ncomix_pkg::GAIN_BITS-1:0]            gain0;
   logic signed [ncomix_pkg::SAMPLE_BITS-1:0]   dry0;
   logic [ncomix_pkg::AMP_BITS-1:0]             tone_mag;
   logic                                        tone_neg;
   logic signed [ncomix_pkg::SAMPLE_BITS-1:0]   mixed;

   // ---------------- configuration registers ----------------
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[ncomix_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      phase_inc_in  = phase_inc_ff;
      wet_target_in = wet_target_ff;
      inv_length_in = inv_length_ff;
      csr_prdata    = '0;
      unique case (reg_index)
         ncomix_pkg::REG_PHASE_INC: begin
            csr_prdata = ncomix_pkg::CSR_DATA_BITS'(phase_inc_ff);
            if (csr_write) begin
               phase_inc_in = csr_pwdata[ncomix_pkg::PHASE_INC_BITS-1:0];
            end
         end
         ncomix_pkg::REG_WET_TARGET: begin
            csr_prdata = ncomix_pkg::CSR_DATA_BITS'(wet_target_ff);
            if (csr_write) begin
               wet_target_in = csr_pwdata[ncomix_pkg::GAIN_BITS-1:0];
            end
         end
         ncomix_pkg::REG_INV_LENGTH: begin
            csr_prdata = ncomix_pkg::CSR_DATA_BITS'(inv_length_ff);
            if (csr_write) begin
               inv_length_in = csr_pwdata[ncomix_pkg::INV_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff  <= ncomix_pkg::PHASE_INC_RESET;
         wet_target_ff <= ncomix_pkg::WET_TARGET_RESET;
         inv_length_ff <= ncomix_pkg::INV_LENGTH_RESET;
      end else begin
         phase_inc_ff  <= phase_inc_in;
         wet_target_ff <= wet_target_in;
         inv_length_ff <= inv_length_in;
      end
   end

   // ---------------- pipeline flow control ----------------
   // A stage loads when its predecessor holds a sample and it is either empty
   // or handing its own sample on in the same cycle.
   always_comb begin
      ctrl.out_load = s2_valid_ff & (~out_valid_ff | rsp_tready);
      ctrl.s2_load  = s1_valid_ff & (~s2_valid_ff | ctrl.out_load);
      ctrl.s1_load  = s0_valid_ff & (~s1_valid_ff | ctrl.s2_load);
      req_tready    = ~s0_valid_ff | ctrl.s1_load;
      ctrl.s0_load  = req_tvalid & req_tready;

      s0_valid_in  = ctrl.s0_load  | (s0_valid_ff  & ~ctrl.s1_load);
      s1_valid_in  = ctrl.s1_load  | (s1_valid_ff  & ~ctrl.s2_load);
      s2_valid_in  = ctrl.s2_load  | (s2_valid_ff  & ~ctrl.out_load);
      out_valid_in = ctrl.out_load | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = mixed;

   // ---------------- datapath ----------------
   ncomix_state u_state (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (ctrl.s0_load),
      .dry_sample            ($signed(req_tdata)),
      .last_in_buffer        (req_tlast),
      .disabling             (req_tuser),
      .phase_increment       (phase_inc_ff),
      .wet_target            (wet_target_ff),
      .inverse_buffer_length (inv_length_ff),
      .phase_ff              (phase0),
      .gain_ff               (gain0),
      .dry_ff                (dry0)
   );

   ncomix_tone #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_tone (
      .clock       (clock),
      .load        (ctrl.s1_load),
      .phase       (phase0),
      .tone_mag_ff (tone_mag),
      .tone_neg_ff (tone_neg)
   );

   ncomix_mix u_mix (
      .clock      (clock),
      .ctrl       (ctrl),
      .dry_sample (dry0),
      .gain       (gain0),
      .tone_mag   (tone_mag),
      .tone_neg   (tone_neg),
      .mixed_ff   (mixed)
   );

endmodule
`default_nettype wire
